/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/imm_pkg.sv */
package imm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;

  typedef enum logic [0:0] {
    CMD_LOAD_A = 1'b0,
    CMD_LOAD_B = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  // Effective matrix dimensions, already clamped to 1..MAX_DIM
  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

  // One classified item on its way from the front to the back
  typedef struct packed {
    logic              we;
    cmd_t              sel;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              trig;
  } q_entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

/* hdl/imm_front.sv */
module imm_front import imm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [DATA_W-1:0] in_element,
  input  dims_t             dims,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_data
);

  logic [CNT_W-1:0] a_cnt_r, a_cnt_nxt;
  logic [CNT_W-1:0] b_cnt_r, b_cnt_nxt;
  logic [CNT_W-1:0] a_cnt_new, b_cnt_new;
  logic [CNT_W-1:0] size_a, size_b;
  logic             accept;
  logic             trig;

  assign size_a   = CNT_W'(dims.nr * dims.nk);
  assign size_b   = CNT_W'(dims.nk * dims.nc);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    a_cnt_new    = a_cnt_r;
    b_cnt_new    = b_cnt_r;
    q_data.we    = 1'b0;
    q_data.sel   = cmd_t'(in_cmd);
    q_data.addr  = '0;
    q_data.data  = in_element;
    // drop items for a matrix that is already full
    if (cmd_t'(in_cmd) == CMD_LOAD_A) begin
      if (a_cnt_r < size_a) begin
        q_data.we   = 1'b1;
        q_data.addr = a_cnt_r[ADDR_W-1:0];
        a_cnt_new   = a_cnt_r + CNT_W'(1);
      end
    end else begin
      if (b_cnt_r < size_b) begin
        q_data.we   = 1'b1;
        q_data.addr = b_cnt_r[ADDR_W-1:0];
        b_cnt_new   = b_cnt_r + CNT_W'(1);
      end
    end
    trig        = (a_cnt_new >= size_a) && (b_cnt_new >= size_b);
    q_data.trig = trig;
    q_push      = accept && (q_data.we || trig);

    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    if (accept) begin
      a_cnt_nxt = trig ? '0 : a_cnt_new;
      b_cnt_nxt = trig ? '0 : b_cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
    end else begin
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
    end
  end

endmodule

/* hdl/imm_queue.sv */
module imm_queue import imm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     full,
  output logic     not_empty
);

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/imm_back.sv */
module imm_back import imm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dims_t                    dims,
  input  logic                     q_valid,
  input  q_entry_t                 q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_product,
  output logic [IDX_W-1:0]         out_row_index,
  output logic [IDX_W-1:0]         out_col_index,
  output logic                     out_last_of_run
);

  logic [DATA_W-1:0] a_mem [STORE_DEPTH];
  logic [DATA_W-1:0] b_mem [STORE_DEPTH];

  back_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt;
  logic [ADDR_W-1:0] b_addr_r, b_addr_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;

  logic [IDX_W-1:0]  nr_m1, nk_m1, nc_m1;
  logic              advance, issue;
  logic              k_last, j_last, i_last;

  // read stage
  logic              s1_v_r, s1_first_r, s1_last_r, s1_end_r;
  logic [IDX_W-1:0]  s1_row_r, s1_col_r;
  logic [DATA_W-1:0] a_q_r, b_q_r;
  // multiply stage
  logic              s2_v_r, s2_first_r, s2_last_r, s2_end_r;
  logic [IDX_W-1:0]  s2_row_r, s2_col_r;
  logic [DATA_W-1:0] prod_r;
  // accumulate and output
  logic [DATA_W-1:0] acc_r, acc_sum;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_product_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;

  assign nr_m1 = IDX_W'(dims.nr - DIM_W'(1));
  assign nk_m1 = IDX_W'(dims.nk - DIM_W'(1));
  assign nc_m1 = IDX_W'(dims.nc - DIM_W'(1));

  // the whole pipe moves unless a finished result is held up
  assign advance = !out_valid_r || !out_stall;
  assign issue   = (state_r == BK_RUN) && advance;
  assign k_last  = (k_r == nk_m1);
  assign j_last  = (j_r == nc_m1);
  assign i_last  = (i_r == nr_m1);

  always_comb begin
    state_nxt    = state_r;
    q_pop        = 1'b0;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    row_base_nxt = row_base_r;
    unique case (state_r)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid && q_data.trig) begin
          state_nxt    = BK_RUN;
          i_nxt        = '0;
          j_nxt        = '0;
          k_nxt        = '0;
          a_addr_nxt   = '0;
          b_addr_nxt   = '0;
          row_base_nxt = '0;
        end
      end
      BK_RUN: begin
        if (advance) begin
          if (!k_last) begin
            k_nxt      = k_r + IDX_W'(1);
            a_addr_nxt = a_addr_r + ADDR_W'(1);
            b_addr_nxt = b_addr_r + ADDR_W'(dims.nc);
          end else begin
            k_nxt = '0;
            if (!j_last) begin
              j_nxt      = j_r + IDX_W'(1);
              a_addr_nxt = row_base_r;
              b_addr_nxt = ADDR_W'(j_nxt);
            end else begin
              j_nxt      = '0;
              b_addr_nxt = '0;
              if (!i_last) begin
                i_nxt        = i_r + IDX_W'(1);
                row_base_nxt = row_base_r + ADDR_W'(dims.nk);
                a_addr_nxt   = row_base_nxt;
              end else begin
                state_nxt = BK_IDLE;
              end
            end
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    a_addr_r   <= a_addr_nxt;
    b_addr_r   <= b_addr_nxt;
    row_base_r <= row_base_nxt;
  end

  // element stores: written from the queue, read once per issued term
  always_ff @(posedge clk) begin
    if (q_pop && q_data.we && q_data.sel == CMD_LOAD_A) begin
      a_mem[q_data.addr] <= q_data.data;
    end
    if (issue) begin
      a_q_r <= a_mem[a_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.we && q_data.sel == CMD_LOAD_B) begin
      b_mem[q_data.addr] <= q_data.data;
    end
    if (issue) begin
      b_q_r <= b_mem[b_addr_r];
    end
  end

  assign acc_sum = s2_first_r ? prod_r : acc_r + prod_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        s1_v_r <= issue;
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_first_r <= (k_r == '0);
      s1_last_r  <= k_last;
      s1_end_r   <= k_last && j_last && i_last;
      s1_row_r   <= i_r;
      s1_col_r   <= j_r;

      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_end_r   <= s1_end_r;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      prod_r     <= DATA_W'(a_q_r * b_q_r);

      if (s2_v_r) begin
        acc_r <= acc_sum;
        if (s2_last_r) begin
          out_product_r <= acc_sum;
          out_row_r     <= s2_row_r;
          out_col_r     <= s2_col_r;
          out_last_r    <= s2_end_r;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product     = out_product_r;
  assign out_row_index   = out_row_r;
  assign out_col_index   = out_col_r;
  assign out_last_of_run = out_last_r;

endmodule

/* hdl/integer_matrix_multiply_unit.sv */
// Channel  | Ports                                     | Handshake
// ---------+-------------------------------------------+-------------------------
// input    | in_cmd, in_element                        | in_valid / in_stall
// result   | out_product, out_row_index, out_col_index,| out_valid / out_stall
//          | out_last_of_run                           |
// config   | cfg_index, cfg_wdata                      | cfg_we, no wait
//
// Loads enter a two-entry queue that the back end drains into its stores only while
// idle; a run fills it. A run does rows_a * cols_b * inner_dim multiply-adds, one per
// cycle while no result is stalled; each term passes the read stage, the multiply
// stage and the accumulator, and each finished product is registered at the output.
// Reset is synchronous; config returns to 8, counters clear, stores keep data.
// A stalled result freezes the MAC pipe; loads still queue up meanwhile.
`include "assert_macros.svh"

module integer_matrix_multiply_unit import imm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DIM_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_cmd,
  input  logic signed [DATA_W-1:0] in_element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_product,
  output logic [IDX_W-1:0]         out_row_index,
  output logic [IDX_W-1:0]         out_col_index,
  output logic                     out_last_of_run
);

  logic [DIM_W-1:0] rows_a_r, rows_a_nxt;
  logic [DIM_W-1:0] inner_dim_r, inner_dim_nxt;
  logic [DIM_W-1:0] cols_b_r, cols_b_nxt;
  dims_t            dims;

  logic     q_push, q_pop, q_full, q_valid;
  q_entry_t q_push_data, q_pop_data;

  always_comb begin
    rows_a_nxt    = rows_a_r;
    inner_dim_nxt = inner_dim_r;
    cols_b_nxt    = cols_b_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS_A:    rows_a_nxt    = cfg_wdata;
        REG_INNER_DIM: inner_dim_nxt = cfg_wdata;
        REG_COLS_B:    cols_b_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(MAX_DIM);
      inner_dim_r <= DIM_W'(MAX_DIM);
      cols_b_r    <= DIM_W'(MAX_DIM);
    end else begin
      rows_a_r    <= rows_a_nxt;
      inner_dim_r <= inner_dim_nxt;
      cols_b_r    <= cols_b_nxt;
    end
  end

  assign dims.nr = clamp_dim(rows_a_r);
  assign dims.nk = clamp_dim(inner_dim_r);
  assign dims.nc = clamp_dim(cols_b_r);

  imm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_element (in_element),
    .dims       (dims),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  imm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  imm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dims            (dims),
    .q_valid         (q_valid),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_product     (out_product),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_last_of_run (out_last_of_run)
  );

  `ASSERT_IMPLIES(a_last_flag, clk, rst_n, out_valid, (out_last_of_run == ((out_row_index == IDX_W'(dims.nr - DIM_W'(1))) && (out_col_index == IDX_W'(dims.nc - DIM_W'(1))))), "last flag does not match final product position")
  `ASSERT_IMPLIES(a_index_range, clk, rst_n, out_valid, ((DIM_W'(out_row_index) < dims.nr) && (DIM_W'(out_col_index) < dims.nc)), "product index outside configured size")
  `ASSERT_NEXT(a_run_restart, clk, rst_n, (out_valid && !out_stall && out_last_of_run), (!out_valid || ((out_row_index == '0) && (out_col_index == '0))), "new run does not start at the first product element")

endmodule
